@@ rtl/fpba_pkg.sv @@
package fpba_pkg;

   // Table geometry. SIZE_BITS must not exceed VALUE_BITS.
   localparam int NUM_BLOCKS = 16;
   localparam int SIZE_BITS  = 16;
   localparam int IDX_BITS   = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int CNT_BITS   = $clog2(NUM_BLOCKS + 1);

   // Fixed field widths of the ports.
   localparam int SEL_BITS    = 4;
   localparam int VALUE_BITS  = 16;
   localparam int POLICY_BITS = 2;
   localparam int BIU_BITS    = 5;
   localparam int CSR_ADDR_BITS = 1;
   localparam int CSR_DATA_BITS = 5;
   localparam int REQ_DATA_BITS = 24;
   localparam int RSP_DATA_BITS = 24;

   // Operation codes carried on tuser of the request channel.
   localparam logic FUNC_LOAD  = 1'b0;
   localparam logic FUNC_ALLOC = 1'b1;

   // Placement rules. The unused code behaves as first fit.
   localparam logic [POLICY_BITS-1:0] POL_FIRST = 2'd0;
   localparam logic [POLICY_BITS-1:0] POL_BEST  = 2'd1;
   localparam logic [POLICY_BITS-1:0] POL_WORST = 2'd2;

   // Register indexes of the configuration port.
   localparam logic [CSR_ADDR_BITS-1:0] REG_FIT_POLICY    = 1'b0;
   localparam logic [CSR_ADDR_BITS-1:0] REG_BLOCKS_IN_USE = 1'b1;

   localparam logic [BIU_BITS-1:0] BIU_RESET = 5'd16;

   typedef struct packed {
      logic                 rd_en;
      logic [IDX_BITS-1:0]  rd_addr;
      logic                 wr_en;
      logic [IDX_BITS-1:0]  wr_addr;
      logic [SIZE_BITS-1:0] wr_data;
   } tbl_req_type;

   typedef struct packed {
      logic                  granted;
      logic [SEL_BITS-1:0]   block_index;
      logic [VALUE_BITS-1:0] remaining_size;
   } res_type;

endpackage

@@ rtl/fpba_table.sv @@
module fpba_table (
   input  logic                           clock,
   input  logic                           reset,
   input  fpba_pkg::tbl_req_type          tbl_req,
   output logic [fpba_pkg::SIZE_BITS-1:0] rd_data
);

   logic [fpba_pkg::SIZE_BITS-1:0]  mem_ff [fpba_pkg::NUM_BLOCKS];
   logic [fpba_pkg::NUM_BLOCKS-1:0] valid_ff;
   logic [fpba_pkg::SIZE_BITS-1:0]  rd_mem_ff;
   logic                            rd_valid_ff;

   always_ff @(posedge clock) begin
      if (tbl_req.wr_en) begin
         mem_ff[tbl_req.wr_addr] <= tbl_req.wr_data;
      end
      if (tbl_req.rd_en) begin
         rd_mem_ff <= mem_ff[tbl_req.rd_addr];
      end
   end

   // An entry never written since reset reads as zero.
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= '0;
         rd_valid_ff <= 1'b0;
      end else begin
         if (tbl_req.wr_en) begin
            valid_ff[tbl_req.wr_addr] <= 1'b1;
         end
         if (tbl_req.rd_en) begin
            rd_valid_ff <= valid_ff[tbl_req.rd_addr];
         end
      end
   end

   assign rd_data = rd_valid_ff ? rd_mem_ff : '0;

endmodule

@@ rtl/fpba_engine.sv @@
module fpba_engine (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_ready,
   input  logic                             req_func,
   input  logic [fpba_pkg::SEL_BITS-1:0]    req_sel,
   input  logic [fpba_pkg::VALUE_BITS-1:0]  req_size,
   input  logic [fpba_pkg::POLICY_BITS-1:0] fit_policy,
   input  logic [fpba_pkg::BIU_BITS-1:0]    blocks_in_use,
   input  logic                             slot_free,
   output logic                             res_valid,
   output fpba_pkg::res_type                res,
   output fpba_pkg::tbl_req_type            tbl_req,
   input  logic [fpba_pkg::SIZE_BITS-1:0]   tbl_rd_data
);

   localparam logic [1:0] S_IDLE   = 2'd0;
   localparam logic [1:0] S_SCAN   = 2'd1;
   localparam logic [1:0] S_FINISH = 2'd2;

   logic [1:0]                     state_ff, state_in;
   logic                           func_ff, func_in;
   logic [fpba_pkg::SEL_BITS-1:0]  sel_ff, sel_in;
   logic [fpba_pkg::SIZE_BITS-1:0] size_ff, size_in;
   logic [fpba_pkg::CNT_BITS-1:0]  limit_ff, limit_in;
   logic [fpba_pkg::CNT_BITS-1:0]  rd_cnt_ff, rd_cnt_in;
   logic [fpba_pkg::CNT_BITS-1:0]  cmp_idx_ff, cmp_idx_in;
   logic                           found_ff, found_in;
   logic [fpba_pkg::IDX_BITS-1:0]  pick_ff, pick_in;
   logic [fpba_pkg::SIZE_BITS-1:0] pick_val_ff, pick_val_in;

   logic [fpba_pkg::CNT_BITS-1:0]  limit_now;
   logic                           fits, take, last, sel_ok;
   logic [fpba_pkg::SIZE_BITS-1:0] left;

   assign limit_now = (32'(blocks_in_use) > fpba_pkg::NUM_BLOCKS)
                      ? fpba_pkg::CNT_BITS'(fpba_pkg::NUM_BLOCKS)
                      : fpba_pkg::CNT_BITS'(blocks_in_use);

   assign fits = tbl_rd_data >= size_ff;
   assign last = fpba_pkg::CNT_BITS'(cmp_idx_ff + 1'b1) == limit_ff;
   assign sel_ok = 32'(sel_ff) < fpba_pkg::NUM_BLOCKS;
   assign left = pick_val_ff - size_ff;

   // Ties keep the earlier block, so only a strictly better size replaces it.
   always_comb begin
      take = 1'b0;
      if (fits) begin
         if (!found_ff) begin
            take = 1'b1;
         end else begin
            case (fit_policy)
               fpba_pkg::POL_BEST:  take = tbl_rd_data < pick_val_ff;
               fpba_pkg::POL_WORST: take = tbl_rd_data > pick_val_ff;
               default:             take = 1'b0;
            endcase
         end
      end
   end

   always_comb begin
      state_in    = state_ff;
      func_in     = func_ff;
      sel_in      = sel_ff;
      size_in     = size_ff;
      limit_in    = limit_ff;
      rd_cnt_in   = rd_cnt_ff;
      cmp_idx_in  = cmp_idx_ff;
      found_in    = found_ff;
      pick_in     = pick_ff;
      pick_val_in = pick_val_ff;
      req_ready   = 1'b0;
      res_valid   = 1'b0;
      res         = '0;
      tbl_req     = '0;

      case (state_ff)
         S_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               func_in    = req_func;
               sel_in     = req_sel;
               size_in    = req_size[fpba_pkg::SIZE_BITS-1:0];
               limit_in   = limit_now;
               found_in   = 1'b0;
               pick_in    = '0;
               cmp_idx_in = '0;
               if (req_func == fpba_pkg::FUNC_ALLOC && limit_now != '0) begin
                  tbl_req.rd_en   = 1'b1;
                  tbl_req.rd_addr = '0;
                  rd_cnt_in       = fpba_pkg::CNT_BITS'(1);
                  state_in        = S_SCAN;
               end else begin
                  state_in = S_FINISH;
               end
            end
         end

         S_SCAN: begin
            // One entry is read ahead of the one being compared.
            if (rd_cnt_ff < limit_ff) begin
               tbl_req.rd_en   = 1'b1;
               tbl_req.rd_addr = rd_cnt_ff[fpba_pkg::IDX_BITS-1:0];
               rd_cnt_in       = rd_cnt_ff + 1'b1;
            end
            if (take) begin
               found_in    = 1'b1;
               pick_in     = cmp_idx_ff[fpba_pkg::IDX_BITS-1:0];
               pick_val_in = tbl_rd_data;
            end
            cmp_idx_in = cmp_idx_ff + 1'b1;
            if (last) begin
               state_in = S_FINISH;
            end
         end

         S_FINISH: begin
            if (slot_free) begin
               res_valid = 1'b1;
               state_in  = S_IDLE;
               if (func_ff == fpba_pkg::FUNC_LOAD) begin
                  if (sel_ok) begin
                     tbl_req.wr_en      = 1'b1;
                     tbl_req.wr_addr    = fpba_pkg::IDX_BITS'(sel_ff);
                     tbl_req.wr_data    = size_ff;
                     res.block_index    = sel_ff;
                     res.remaining_size = fpba_pkg::VALUE_BITS'(size_ff);
                  end
               end else if (found_ff) begin
                  tbl_req.wr_en      = 1'b1;
                  tbl_req.wr_addr    = pick_ff;
                  tbl_req.wr_data    = left;
                  res.granted        = 1'b1;
                  res.block_index    = fpba_pkg::SEL_BITS'(pick_ff);
                  res.remaining_size = fpba_pkg::VALUE_BITS'(left);
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff     <= func_in;
      sel_ff      <= sel_in;
      size_ff     <= size_in;
      limit_ff    <= limit_in;
      rd_cnt_ff   <= rd_cnt_in;
      cmp_idx_ff  <= cmp_idx_in;
      found_ff    <= found_in;
      pick_ff     <= pick_in;
      pick_val_ff <= pick_val_in;
   end

   a_res_needs_slot: assert property (@(posedge clock) disable iff (reset)
      res_valid |-> slot_free)
      else $error("result produced while the output register is occupied");

   a_scan_in_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_SCAN |-> cmp_idx_ff < limit_ff)
      else $error("scan compares an entry beyond the blocks in use");

   a_write_on_finish: assert property (@(posedge clock) disable iff (reset)
      tbl_req.wr_en |-> (state_ff == S_FINISH && res_valid))
      else $error("table written outside the finishing step");

   a_pick_fits: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH && func_ff == fpba_pkg::FUNC_ALLOC && found_ff)
      |-> pick_val_ff >= size_ff)
      else $error("chosen block is smaller than the request");

   a_no_read_in_finish: assert property (@(posedge clock) disable iff (reset)
      state_ff == S_FINISH |-> !tbl_req.rd_en)
      else $error("table read while a result is being written back");

endmodule

@@ rtl/fit_policy_block_allocator.sv @@
// Channel  Direction  Handshake             Payload
// req      in         req_tvalid/tready     tuser: func; tdata: block_select, size_value
// rsp      out        rsp_tvalid/tready     tuser: granted; tdata: block_index, remaining_size
// csr      in         csr_we                csr_addr: register index; csr_wdata: value
//
// An allocate scans the first min(blocks_in_use, 16) entries, all 16 at the reset setting:
// the free-size table sits in one synchronous memory with one read and one write port,
// and the scan reads the entries in order before the chosen block is written back.
// Reset is synchronous; it clears the table (through per-entry valid bits) and the result
// valid flag and loads the configuration registers' reset values, with no clearing pass.
// A request is taken while a previous result still waits in the output register;
// the engine holds its finished result until that register is free.
module fit_policy_block_allocator (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [fpba_pkg::REQ_DATA_BITS-1:0]  req_tdata,  // block_select, size_value, zeros
   input  logic                                req_tuser,  // func
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   output logic [fpba_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,  // block_index, remaining_size, zeros
   output logic                                rsp_tuser,  // granted
   input  logic                                csr_we,
   input  logic [fpba_pkg::CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [fpba_pkg::CSR_DATA_BITS-1:0]  csr_wdata
);

   logic [fpba_pkg::POLICY_BITS-1:0] fit_policy_ff;
   logic [fpba_pkg::BIU_BITS-1:0]    blocks_in_use_ff;
   logic                             rsp_valid_ff, rsp_valid_in;
   fpba_pkg::res_type                rsp_res_ff, rsp_res_in;

   logic                             slot_free;
   logic                             res_valid;
   fpba_pkg::res_type                res;
   fpba_pkg::tbl_req_type            tbl_req;
   logic [fpba_pkg::SIZE_BITS-1:0]   tbl_rd_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         fit_policy_ff    <= fpba_pkg::POL_FIRST;
         blocks_in_use_ff <= fpba_pkg::BIU_RESET;
      end else if (csr_we) begin
         case (csr_addr)
            fpba_pkg::REG_FIT_POLICY:
               fit_policy_ff <= csr_wdata[fpba_pkg::POLICY_BITS-1:0];
            fpba_pkg::REG_BLOCKS_IN_USE:
               blocks_in_use_ff <= csr_wdata[fpba_pkg::BIU_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   assign slot_free = !rsp_valid_ff || rsp_tready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_res_in   = rsp_res_ff;
      if (res_valid) begin
         rsp_valid_in = 1'b1;
         rsp_res_in   = res;
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_res_ff <= rsp_res_in;
   end

   fpba_engine u_engine (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_tvalid),
      .req_ready     (req_tready),
      .req_func      (req_tuser),
      .req_sel       (req_tdata[fpba_pkg::SEL_BITS-1:0]),
      .req_size      (req_tdata[fpba_pkg::SEL_BITS +: fpba_pkg::VALUE_BITS]),
      .fit_policy    (fit_policy_ff),
      .blocks_in_use (blocks_in_use_ff),
      .slot_free     (slot_free),
      .res_valid     (res_valid),
      .res           (res),
      .tbl_req       (tbl_req),
      .tbl_rd_data   (tbl_rd_data)
   );

   fpba_table u_table (
      .clock   (clock),
      .reset   (reset),
      .tbl_req (tbl_req),
      .rd_data (tbl_rd_data)
   );

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_res_ff.granted;
   assign rsp_tdata  = {{(fpba_pkg::RSP_DATA_BITS - fpba_pkg::SEL_BITS
                          - fpba_pkg::VALUE_BITS){1'b0}},
                        rsp_res_ff.remaining_size, rsp_res_ff.block_index};

endmodule
